// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/whpd_pkg.sv =====
// Types, codes and helper functions for the WAV header parser.
package whpd_pkg;

	localparam int TDATA_W = 136;

	localparam logic [1:0] PHASE_HEADER = 2'd0;
	localparam logic [1:0] PHASE_DATA   = 2'd1;
	localparam logic [1:0] PHASE_HALT   = 2'd2;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_NOT_RIFF  = 2'd0;
	localparam logic [1:0] ERR_NOT_PCM   = 2'd1;
	localparam logic [1:0] ERR_CHANNELS  = 2'd2;
	localparam logic [1:0] ERR_WIDTH     = 2'd3;

	localparam logic [5:0] OFF_TAG_END      = 6'd3;
	localparam logic [5:0] OFF_FORMAT_END   = 6'd21;
	localparam logic [5:0] OFF_CHANNELS_END = 6'd23;
	localparam logic [5:0] OFF_RATE_END     = 6'd27;
	localparam logic [5:0] OFF_BITS_END     = 6'd35;
	localparam logic [5:0] HEADER_LAST      = 6'd43;

	localparam logic [31:0] TAG_RIFF   = 32'h4646_4952;
	localparam logic [15:0] PCM_FORMAT = 16'd1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       start_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  error_code;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [31:0] payload_bytes;
		logic        channel_index;
		logic [31:0] sample_value;
		logic        last_sample;
	} result_t;

	function automatic logic [1:0] field_pos(input logic [5:0] off);
		logic [1:0] pos;
		case (off) inside
			[6'd20:6'd23]: pos = {1'b0, off[0]};
			[6'd32:6'd35]: pos = {1'b0, off[0]};
			default:       pos = off[1:0];
		endcase
		return pos;
	endfunction

	function automatic logic [31:0] gather(input logic [31:0] acc, input logic [1:0] pos,
			input logic [7:0] b);
		logic [31:0] ext;
		ext = {24'd0, b};
		if (pos == 2'd0) begin
			return ext;
		end
		return acc | (ext << {pos, 3'b000});
	endfunction

endpackage

// ===== rtl/wav_header_parse_deinterleave.sv =====
// WAV header parser and sample deinterleaver, top level.
// Takes a WAV file one byte per cycle, sustained unless the sink stalls; the byte is held in the
// input register and its result item in the result register, and the rate is set by the single
// per-byte parse step between the two registers. The 44-byte header gives one header item
// (or one error item, after which bytes are ignored until the next start of file); each complete
// data sample then gives one sample item, alternating left and right for stereo, with tlast on
// the final sample. Byte offsets 3 and 21 check the RIFF tag and the PCM format; a partial
// trailing sample is dropped. Input tready falls only while a result item waits and the sink
// stalls.
module wav_header_parse_deinterleave (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // byte_value
	input  logic                          s_axis_tuser,  // start_of_file
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// error_code, channel_count, rate_hz, sample_bits, payload_bytes, channel_index,
	// sample_value, zero fill
	output logic [whpd_pkg::TDATA_W-1:0]  m_axis_tdata,
	output logic [1:0]                    m_axis_tuser,  // kind
	output logic                          m_axis_tlast   // last_sample
);
	import whpd_pkg::*;

	in_item_t in_item, item_s1;
	result_t  res;
	logic     valid_s1, advance, step, res_valid;

	assign in_item.byte_value    = s_axis_tdata;
	assign in_item.start_of_file = s_axis_tuser;
	assign step = valid_s1 && advance;

	whpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	whpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	whpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== rtl/whpd_in_stage.sv =====
// Input register stage: capture one byte item per cycle while in_ready is high.
module whpd_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  whpd_pkg::in_item_t  in_item,
	input  logic                advance,
	output logic                valid_s1,
	output whpd_pkg::in_item_t  item_s1
);
	import whpd_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/whpd_parser.sv =====
// Parse state and per-byte header walk and sample assembly.
module whpd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  whpd_pkg::in_item_t  item_s1,
	output logic                res_valid,
	output whpd_pkg::result_t   res
);
	import whpd_pkg::*;

	logic [1:0]  phase_q, phase_e, phase_n;
	logic [5:0]  hoff_q, hoff_e, hoff_n;
	logic [31:0] fa_q, fa_e, fa_n;
	logic [15:0] ch_q, ch_e, ch_n;
	logic [31:0] rate_q, rate_e, rate_n;
	logic [15:0] bits_q, bits_e, bits_n;
	logic [31:0] rem_q, rem_e, rem_n;
	logic [1:0]  bis_q, bis_e, bis_n;
	logic        tog_q, tog_e, tog_n;
	logic [31:0] hdr_fa, dat_fa, rem_dec;
	logic [12:0] width_e;
	logic        width_ok, sof;
	logic [7:0]  b;

	assign sof = item_s1.start_of_file;
	assign b   = item_s1.byte_value;

	assign phase_e = sof ? PHASE_HEADER : phase_q;
	assign hoff_e  = sof ? 6'd0 : hoff_q;
	assign fa_e    = sof ? 32'd0 : fa_q;
	assign ch_e    = sof ? 16'd0 : ch_q;
	assign rate_e  = sof ? 32'd0 : rate_q;
	assign bits_e  = sof ? 16'd0 : bits_q;
	assign rem_e   = sof ? 32'd0 : rem_q;
	assign bis_e   = sof ? 2'd0 : bis_q;
	assign tog_e   = sof ? 1'b0 : tog_q;

	assign width_e  = bits_e[15:3];
	assign width_ok = (width_e != 13'd0) && (width_e <= 13'd4);
	assign hdr_fa   = gather(fa_e, field_pos(hoff_e), b);
	assign dat_fa   = gather(fa_e, bis_e, b);
	assign rem_dec  = rem_e - 32'd1;

	always_comb begin
		phase_n   = phase_e;
		hoff_n    = hoff_e;
		fa_n      = fa_e;
		ch_n      = ch_e;
		rate_n    = rate_e;
		bits_n    = bits_e;
		rem_n     = rem_e;
		bis_n     = bis_e;
		tog_n     = tog_e;
		res_valid = 1'b0;
		res       = '0;
		case (phase_e)
			PHASE_HEADER: begin
				if (hoff_e > HEADER_LAST) begin
					phase_n = PHASE_HALT;
				end else begin
					fa_n   = hdr_fa;
					hoff_n = 6'(hoff_e + 6'd1);
					case (hoff_e)
						OFF_TAG_END: begin
							if (hdr_fa != TAG_RIFF) begin
								res_valid      = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_NOT_RIFF;
								phase_n        = PHASE_HALT;
							end
						end
						OFF_FORMAT_END: begin
							if (hdr_fa[15:0] != PCM_FORMAT) begin
								res_valid      = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_NOT_PCM;
								phase_n        = PHASE_HALT;
							end
						end
						OFF_CHANNELS_END: ch_n = hdr_fa[15:0];
						OFF_RATE_END: rate_n = hdr_fa;
						OFF_BITS_END: bits_n = hdr_fa[15:0];
						HEADER_LAST: begin
							rem_n     = hdr_fa;
							res_valid = 1'b1;
							if (ch_e != 16'd1 && ch_e != 16'd2) begin
								res.kind       = KIND_ERROR;
								res.error_code = ERR_CHANNELS;
								phase_n        = PHASE_HALT;
							end else if (!width_ok) begin
								res.kind       = KIND_ERROR;
								res.error_code = ERR_WIDTH;
								phase_n        = PHASE_HALT;
							end else begin
								res.kind          = KIND_HEADER;
								res.channel_count = ch_e;
								res.rate_hz       = rate_e;
								res.sample_bits   = bits_e;
								res.payload_bytes = hdr_fa;
								bis_n   = 2'd0;
								tog_n   = 1'b0;
								fa_n    = 32'd0;
								phase_n = (hdr_fa == 32'd0) ? PHASE_HALT : PHASE_DATA;
							end
						end
						default: ;
					endcase
				end
			end
			PHASE_DATA: begin
				if (!width_ok || rem_e == 32'd0) begin
					phase_n = PHASE_HALT;
				end else begin
					fa_n  = dat_fa;
					rem_n = rem_dec;
					if (({1'b0, bis_e} + 3'd1) >= width_e[2:0]) begin
						res_valid         = 1'b1;
						res.kind          = KIND_SAMPLE;
						res.channel_index = tog_e;
						res.sample_value  = dat_fa;
						res.last_sample   = rem_dec < {29'd0, width_e[2:0]};
						bis_n = 2'd0;
						if (ch_e == 16'd2) begin
							tog_n = !tog_e;
						end
					end else begin
						bis_n = 2'(bis_e + 2'd1);
					end
					if (rem_dec == 32'd0) begin
						phase_n = PHASE_HALT;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_HEADER;
			hoff_q  <= 6'd0;
			fa_q    <= 32'd0;
			ch_q    <= 16'd0;
			rate_q  <= 32'd0;
			bits_q  <= 16'd0;
			rem_q   <= 32'd0;
			bis_q   <= 2'd0;
			tog_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			hoff_q  <= hoff_n;
			fa_q    <= fa_n;
			ch_q    <= ch_n;
			rate_q  <= rate_n;
			bits_q  <= bits_n;
			rem_q   <= rem_n;
			bis_q   <= bis_n;
			tog_q   <= tog_n;
		end
	end

endmodule

// ===== rtl/whpd_out_stage.sv =====
// Result register: hold one result item until the sink takes it.
module whpd_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          res_valid,
	input  whpd_pkg::result_t             res,
	output logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [whpd_pkg::TDATA_W-1:0]  out_data,
	output logic [1:0]                    out_user,
	output logic                          out_last
);
	import whpd_pkg::*;

	result_t res_q;

	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_data = {5'd0, res_q.sample_value, res_q.channel_index, res_q.payload_bytes,
		res_q.sample_bits, res_q.rate_hz, res_q.channel_count, res_q.error_code};
	assign out_user = res_q.kind;
	assign out_last = res_q.last_sample;

endmodule

// ===== rtl/whpd_checker.sv =====
// Port-level checker for the WAV header parser, bound to the top level.
`include "assert_macros.svh"

module whpd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [whpd_pkg::TDATA_W-1:0]  m_axis_tdata,
	input logic [1:0]                    m_axis_tuser,
	input logic                          m_axis_tlast
);
	import whpd_pkg::*;

	`ASSERT_NEXT(a_out_hold_valid, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NEXT(a_out_hold_data, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ASSERT_SAME(a_last_on_sample, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_SAMPLE)
	`ASSERT_SAME(a_error_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_ERROR, m_axis_tdata[TDATA_W-1:2] == '0)
	`ASSERT_SAME(a_header_channels, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_HEADER, m_axis_tdata[17:2] == 16'd1 || m_axis_tdata[17:2] == 16'd2)

endmodule

bind wav_header_parse_deinterleave whpd_checker u_whpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== tb/wav_header_parse_deinterleave_tb.sv =====
// Self-checking testbench for the WAV header parser: byte stream in, header/sample/error items out.
module wav_header_parse_deinterleave_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import whpd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 150;
	localparam logic [31:0] WAVE_LE = 32'h4556_4157;
	localparam logic [31:0] FMT_LE = 32'h2074_6D66;
	localparam logic [31:0] DATA_LE = 32'h6174_6164;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	wav_header_parse_deinterleave dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [1:0] parse_state;
	logic [5:0] hdr_pos;
	logic [31:0] field_acc;
	logic [15:0] hdr_channels;
	logic [31:0] hdr_rate;
	logic [15:0] hdr_bits;
	logic [31:0] data_left;
	logic [1:0] sample_pos;
	logic next_channel;

	result_t expected_results[$];
	int errors = 0;
	int items_sent = 0;
	bit src_quiet = 0;
	bit sink_quiet = 0;

	function automatic logic [1:0] byte_lane(input logic [5:0] pos);
		if ((pos >= 6'd20 && pos <= 6'd23) || (pos >= 6'd32 && pos <= 6'd35)) begin
			return {1'b0, pos[0]};
		end
		return pos[1:0];
	endfunction

	function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [1:0] lane,
			input logic [7:0] b);
		if (lane == 2'd0) begin
			return {24'd0, b};
		end
		return acc | ({24'd0, b} << (8 * lane));
	endfunction

	task automatic clear_parser();
		parse_state = PHASE_HEADER;
		hdr_pos = '0;
		field_acc = '0;
		hdr_channels = '0;
		hdr_rate = '0;
		hdr_bits = '0;
		data_left = '0;
		sample_pos = '0;
		next_channel = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic sof);
		result_t r;
		bit got;
		logic [5:0] off;
		int unsigned width;
		r = '0;
		got = 0;
		if (sof) begin
			clear_parser();
		end
		width = hdr_bits / 8;
		if (parse_state == PHASE_HEADER) begin
			if (hdr_pos > HEADER_LAST) begin
				parse_state = PHASE_HALT;
			end else begin
				off = hdr_pos;
				field_acc = merge_byte(field_acc, byte_lane(off), b);
				hdr_pos = off + 6'd1;
				case (off)
					OFF_TAG_END: begin
						if (field_acc != TAG_RIFF) begin
							r.kind = KIND_ERROR;
							r.error_code = ERR_NOT_RIFF;
							got = 1;
						end
					end
					OFF_FORMAT_END: begin
						if (field_acc[15:0] != PCM_FORMAT) begin
							r.kind = KIND_ERROR;
							r.error_code = ERR_NOT_PCM;
							got = 1;
						end
					end
					OFF_CHANNELS_END: hdr_channels = field_acc[15:0];
					OFF_RATE_END: hdr_rate = field_acc;
					OFF_BITS_END: hdr_bits = field_acc[15:0];
					HEADER_LAST: begin
						data_left = field_acc;
						width = hdr_bits / 8;
						got = 1;
						if (hdr_channels != 16'd1 && hdr_channels != 16'd2) begin
							r.kind = KIND_ERROR;
							r.error_code = ERR_CHANNELS;
						end else if (width < 1 || width > 4) begin
							r.kind = KIND_ERROR;
							r.error_code = ERR_WIDTH;
						end else begin
							r.kind = KIND_HEADER;
							r.channel_count = hdr_channels;
							r.rate_hz = hdr_rate;
							r.sample_bits = hdr_bits;
							r.payload_bytes = data_left;
							sample_pos = '0;
							next_channel = 1'b0;
							field_acc = '0;
							parse_state = (data_left == 0) ? PHASE_HALT : PHASE_DATA;
						end
					end
					default: ;
				endcase
				if (got && r.kind == KIND_ERROR) begin
					parse_state = PHASE_HALT;
				end
			end
		end else if (parse_state == PHASE_DATA) begin
			if (width < 1 || width > 4 || data_left == 0) begin
				parse_state = PHASE_HALT;
			end else begin
				field_acc = merge_byte(field_acc, sample_pos, b);
				data_left = data_left - 32'd1;
				if (sample_pos + 32'd1 >= width) begin
					r.kind = KIND_SAMPLE;
					r.channel_index = next_channel;
					r.sample_value = field_acc;
					r.last_sample = (data_left < width);
					got = 1;
					sample_pos = '0;
					if (hdr_channels == 16'd2) begin
						next_channel = ~next_channel;
					end
				end else begin
					sample_pos = sample_pos + 2'd1;
				end
				if (data_left == 0) begin
					parse_state = PHASE_HALT;
				end
			end
		end
		if (got) begin
			expected_results = {expected_results, r};
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic sof);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= sof;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		parse_byte(b, sof);
		items_sent++;
	endtask

	task automatic send_header(input logic [31:0] tag, input logic [15:0] fmt,
			input logic [15:0] chans, input logic [31:0] rate, input logic [15:0] bits,
			input logic [31:0] size, input int count = 44);
		logic [351:0] image;
		image = {size, DATA_LE, bits, 16'($urandom), 32'($urandom), rate, chans, fmt,
			32'd16, FMT_LE, WAVE_LE, 32'($urandom), tag};
		for (int i = 0; i < count; i++) begin
			send_byte(image[8*i +: 8], i == 0);
		end
	endtask

	task automatic send_data(input int n);
		repeat (n) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected item kind %h tdata %h, expected none", $time,
				m_axis_tuser, m_axis_tdata);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		check_field("kind", want.kind, m_axis_tuser);
		check_field("error_code", want.error_code, m_axis_tdata[1:0]);
		check_field("channel_count", want.channel_count, m_axis_tdata[17:2]);
		check_field("rate_hz", want.rate_hz, m_axis_tdata[49:18]);
		check_field("sample_bits", want.sample_bits, m_axis_tdata[65:50]);
		check_field("payload_bytes", want.payload_bytes, m_axis_tdata[97:66]);
		check_field("channel_index", want.channel_index, m_axis_tdata[98]);
		check_field("sample_value", want.sample_value, m_axis_tdata[130:99]);
		check_field("tdata fill", 32'd0, m_axis_tdata[135:131]);
		check_field("last_sample", want.last_sample, m_axis_tlast);
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			check_result();
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** wav_header_parse_deinterleave: FAILED **");
		$finish;
	end

	task automatic test_pcm_files();
		send_header(TAG_RIFF, PCM_FORMAT, 16'd1, 32'd48000, 16'd16, 32'd6);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_data(2);
		src_quiet = 1;
		send_header(TAG_RIFF, PCM_FORMAT, 16'd2, 32'hFFFF_FFFF, 16'd8, 32'd5);
		send_data(8);
		src_quiet = 0;
		sink_quiet = 1;
		// two full 32-bit samples, then drop one trailing byte
		send_header(TAG_RIFF, PCM_FORMAT, 16'd2, 32'd0, 16'd32, 32'd9);
		send_data(9);
		sink_quiet = 0;
		send_header(TAG_RIFF, PCM_FORMAT, 16'd1, 32'd44100, 16'd24, 32'd7);
		send_data(7);
		wait_all_results();
	endtask

	task automatic test_header_errors();
		send_header(TAG_RIFF ^ 32'h8000_0000, PCM_FORMAT, 16'd1, 32'd8000, 16'd8, 32'd4, 8);
		send_header(32'd0, PCM_FORMAT, 16'd1, 32'd8000, 16'd8, 32'd4, 6);
		send_header(TAG_RIFF, 16'd3, 16'd1, 32'd8000, 16'd8, 32'd4, 30);
		send_header(TAG_RIFF, 16'h0101, 16'd1, 32'd8000, 16'd8, 32'd4, 22);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd0, 32'd8000, 16'd16, 32'd4);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd3, 32'd8000, 16'd16, 32'd4);
		send_header(TAG_RIFF, PCM_FORMAT, 16'hFFFF, 32'd8000, 16'd16, 32'd4);
		send_data(2);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd2, 32'd8000, 16'd7, 32'd4);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd2, 32'd8000, 16'd40, 32'd4);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd1, 32'd8000, 16'hFFFF, 32'd4);
		send_data(3);
	endtask

	task automatic test_empty_chunk();
		send_header(TAG_RIFF, PCM_FORMAT, 16'd1, 32'd22050, 16'd16, 32'd0);
		send_data(3);
		// hold the source until every item has drained
		wait_all_results();
	endtask

	task automatic test_restart();
		send_header(TAG_RIFF, PCM_FORMAT, 16'd2, 32'd96000, 16'd16, 32'd8, 30);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd2, 32'd96000, 16'd16, 32'hFFFF_FFF0);
		send_data(5);
		send_header(TAG_RIFF, PCM_FORMAT, 16'd1, 32'd16000, 16'd12, 32'd4);
		send_data(4);
		wait_all_results();
	endtask

	task automatic test_random_files();
		int goal;
		int sel;
		int corrupt;
		logic [31:0] tag;
		logic [15:0] fmt;
		logic [15:0] chans;
		logic [15:0] bits;
		logic [31:0] size;
		goal = items_sent + RANDOM_BYTES;
		while (items_sent < goal) begin
			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			chans = 16'($urandom_range(1, 2));
			bits = 16'(8 * $urandom_range(1, 4) + $urandom_range(0, 7));
			if (sel < 70) begin
				if ($urandom_range(0, 4) == 0) begin
					send_header(TAG_RIFF, PCM_FORMAT, chans, $urandom, bits, $urandom);
					send_data($urandom_range(0, 12));
				end else begin
					size = $urandom_range(0, 24);
					send_header(TAG_RIFF, PCM_FORMAT, chans, $urandom, bits, size);
					send_data(size + $urandom_range(0, 3));
				end
			end else if (sel < 85) begin
				tag = TAG_RIFF;
				fmt = PCM_FORMAT;
				corrupt = $urandom_range(0, 3);
				case (corrupt)
					0: tag = $urandom;
					1: fmt = 16'($urandom);
					2: chans = 16'($urandom);
					default: bits = 16'($urandom);
				endcase
				send_header(tag, fmt, chans, $urandom, bits, $urandom_range(0, 16));
				send_data($urandom_range(0, 4));
			end else if (sel < 95) begin
				repeat ($urandom_range(1, 16)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end else begin
				send_header(TAG_RIFF, PCM_FORMAT, chans, $urandom, bits, $urandom_range(1, 16),
					$urandom_range(1, 43));
			end
		end
	endtask

	initial begin
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pcm_files();
		test_header_errors();
		test_empty_chunk();
		test_restart();
		test_random_files();
		wait_all_results();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("** wav_header_parse_deinterleave: PASSED **");
		end else begin
			$display("** wav_header_parse_deinterleave: FAILED **");
		end
		$finish;
	end

endmodule
